>>> sv/mtpq_pkg.sv
// mtpq_pkg: shared types, codes and sizes for the min-turn priority queue
// no dependencies; imported by every module of the block but mtpq_ram
`timescale 1ns / 1ps
`default_nettype none

package mtpq_pkg;

  // field widths fixed by the interface
  localparam int OP_W  = 2;
  localparam int SYM_W = 8;
  localparam int KEY_W = 31;
  localparam int OCC_W = 8;
  localparam int ST_W  = 2;

  // default number of queue slots
  localparam int QUEUE_DEPTH_DEF = 128;

  typedef logic [OP_W-1:0] opcode_t;
  typedef logic [ST_W-1:0] status_t;

  // operation codes
  localparam opcode_t OP_ENQUEUE = 2'd0;
  localparam opcode_t OP_DEQUEUE = 2'd1;
  localparam opcode_t OP_PEEK    = 2'd2;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // one stored entry
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [KEY_W-1:0] turn;
    logic [KEY_W-1:0] seq;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller states
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_SCAN,
    CS_SHIFT,
    CS_FINISH
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic    capture;
    logic    enq_write;
    logic    scan_start;
    logic    scan_step;
    logic    shift_start;
    logic    shift_step;
    logic    count_dec;
    logic    load_out;
    status_t out_status;
    logic    out_entry;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    opcode_t op;
    logic    empty;
    logic    full;
    logic    scan_done;
    logic    shift_done;
    logic    out_busy;
  } stat_t;

endpackage

`default_nettype wire

>>> sv/min_turn_priority_queue.sv
// min_turn_priority_queue: top level, bounded priority queue keyed by turn then sequence
// depends on mtpq_pkg, mtpq_ctrl, mtpq_dp (and mtpq_ram below it)
//
//   channel  | ports                                                  | flow control
//   ---------+--------------------------------------------------------+-------------
//   in       | in_opcode in_symbol in_due_turn in_sequence_req        | in_valid / in_stall
//   out      | out_status out_symbol out_due_turn out_sequence        | out_valid / out_stall
//            | out_occupancy                                          |
//
// one operation at a time; an accepted beat is decoded and its result loaded into the
// output register for enqueue, unused opcode or empty queue; peek first scans the N
// entries held, one entry per cycle over the ram read port; dequeue then adds a
// shift-down of the entries above the slot removed.
// reset is synchronous, active low, and empties the queue; the ram itself is not cleared.
// a result waiting on out_stall does not block the next input beat; the following
// result waits in the controller until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module min_turn_priority_queue #(
  parameter int QUEUE_DEPTH = mtpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire mtpq_pkg::opcode_t            in_opcode,
  input  wire logic [mtpq_pkg::SYM_W-1:0]   in_symbol,
  input  wire logic [mtpq_pkg::KEY_W-1:0]   in_due_turn,
  input  wire logic [mtpq_pkg::KEY_W-1:0]   in_sequence_req,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output mtpq_pkg::status_t                 out_status,
  output logic      [mtpq_pkg::SYM_W-1:0]   out_symbol,
  output logic      [mtpq_pkg::KEY_W-1:0]   out_due_turn,
  output logic      [mtpq_pkg::KEY_W-1:0]   out_sequence,
  output logic      [mtpq_pkg::OCC_W-1:0]   out_occupancy
);
  import mtpq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  mtpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, scan and result register
  mtpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (in_opcode),
    .in_symbol       (in_symbol),
    .in_due_turn     (in_due_turn),
    .in_sequence_req (in_sequence_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_symbol      (out_symbol),
    .out_due_turn    (out_due_turn),
    .out_sequence    (out_sequence),
    .out_occupancy   (out_occupancy)
  );

endmodule

`default_nettype wire

>>> sv/mtpq_ram.sv
// mtpq_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mtpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/mtpq_ctrl.sv
// mtpq_ctrl: controller state machine sequencing decode, scan, shift and result
// depends on mtpq_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtpq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire mtpq_pkg::stat_t stat,
  output mtpq_pkg::cmd_t       cmd
);
  import mtpq_pkg::*;

  ctrl_state_t state_r, state_nxt;
  status_t     res_status_r, res_status_nxt;
  logic        res_entry_r, res_entry_nxt;

  // state and result kind registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= CS_IDLE;
      res_status_r <= ST_OK;
      res_entry_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
      res_entry_r  <= res_entry_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    cmd            = '0;
    cmd.out_status = res_status_r;
    cmd.out_entry  = res_entry_r;
    in_stall       = (state_r != CS_IDLE);
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = CS_DECODE;
        end
      end
      CS_DECODE: begin
        res_status_nxt = ST_OK;
        res_entry_nxt  = 1'b0;
        state_nxt      = CS_FINISH;
        case (stat.op) inside
          OP_ENQUEUE: begin
            if (stat.full) begin
              res_status_nxt = ST_FULL;
            end else begin
              cmd.enq_write = 1'b1;
            end
          end
          OP_DEQUEUE, OP_PEEK: begin
            if (stat.empty) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              cmd.scan_start = 1'b1;
              res_entry_nxt  = 1'b1;
              state_nxt      = CS_SCAN;
            end
          end
          default: begin
            // unused opcode: plain ok result, nothing changes
            res_status_nxt = ST_OK;
          end
        endcase
      end
      CS_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          if (stat.op == OP_DEQUEUE) begin
            cmd.shift_start = 1'b1;
            state_nxt       = CS_SHIFT;
          end else begin
            state_nxt = CS_FINISH;
          end
        end
      end
      CS_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_done) begin
          cmd.count_dec = 1'b1;
          state_nxt     = CS_FINISH;
        end
      end
      CS_FINISH: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/mtpq_dp.sv
// mtpq_dp: datapath with entry ram, count, min scan, shift-down and result register
// depends on mtpq_pkg and mtpq_ram
`timescale 1ns / 1ps
`default_nettype none

module mtpq_dp #(
  parameter int QUEUE_DEPTH = mtpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mtpq_pkg::cmd_t               cmd,
  output mtpq_pkg::stat_t                   stat,
  input  wire mtpq_pkg::opcode_t            in_opcode,
  input  wire logic [mtpq_pkg::SYM_W-1:0]   in_symbol,
  input  wire logic [mtpq_pkg::KEY_W-1:0]   in_due_turn,
  input  wire logic [mtpq_pkg::KEY_W-1:0]   in_sequence_req,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output mtpq_pkg::status_t                 out_status,
  output logic      [mtpq_pkg::SYM_W-1:0]   out_symbol,
  output logic      [mtpq_pkg::KEY_W-1:0]   out_due_turn,
  output logic      [mtpq_pkg::KEY_W-1:0]   out_sequence,
  output logic      [mtpq_pkg::OCC_W-1:0]   out_occupancy
);
  import mtpq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  opcode_t            op_r;
  entry_t             item_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  entry_t             best_r, best_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic               out_valid_r;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_ent;
  logic               better;
  logic               take;
  logic               rd_issue;

  mtpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata);

  // min compare: turn first, sequence breaks ties, earlier slot wins equal keys
  assign better = {rd_ent.turn, rd_ent.seq} < {best_r.turn, best_r.seq};
  assign take   = cmd.scan_step && rd_vld_r && ((rd_idx_r == '0) || better);

  always_comb begin
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    if (take) begin
      best_nxt     = rd_ent;
      best_idx_nxt = rd_idx_r;
    end
  end

  // read pointer shared by scan and shift
  assign rd_issue = (cmd.scan_step || cmd.shift_step) && (ptr_r < count_r);

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.scan_start) begin
      ptr_nxt = '0;
    end else if (cmd.shift_start) begin
      ptr_nxt = CNT_W'(best_idx_nxt) + 1'b1;
    end else if (rd_issue) begin
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  // ram write: append on enqueue, move down one slot during shift
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[IDX_W-1:0];
    ram_wdata = item_r;
    if (cmd.enq_write) begin
      ram_we = 1'b1;
    end else if (cmd.shift_step && rd_vld_r) begin
      ram_we    = 1'b1;
      ram_waddr = rd_idx_r - 1'b1;
      ram_wdata = ram_rdata;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.enq_write) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.count_dec) begin
        count_r <= count_r - 1'b1;
      end
      rd_vld_r <= rd_issue;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_opcode;
      item_r <= '{symbol: in_symbol, turn: in_due_turn, seq: in_sequence_req};
    end
    ptr_r      <= ptr_nxt;
    rd_idx_r   <= ptr_r[IDX_W-1:0];
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    if (cmd.load_out) begin
      out_status    <= cmd.out_status;
      out_symbol    <= cmd.out_entry ? best_r.symbol : '0;
      out_due_turn  <= cmd.out_entry ? best_r.turn : '0;
      out_sequence  <= cmd.out_entry ? best_r.seq : '0;
      out_occupancy <= OCC_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;

  // status back to the controller
  assign stat.op         = op_r;
  assign stat.empty      = (count_r == '0);
  assign stat.full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.scan_done  = rd_vld_r && (CNT_W'(rd_idx_r) == (count_r - 1'b1));
  assign stat.shift_done = !rd_vld_r && (ptr_r >= count_r);
  assign stat.out_busy   = out_valid_r && out_stall;

endmodule

`default_nettype wire

>>> sv/mtpq_checker.sv
// mtpq_checker: port-level assertions for min_turn_priority_queue, bound to the top level
// depends on mtpq_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtpq_checker #(
  parameter int QUEUE_DEPTH = mtpq_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire mtpq_pkg::status_t          out_status,
  input wire logic [mtpq_pkg::SYM_W-1:0] out_symbol,
  input wire logic [mtpq_pkg::KEY_W-1:0] out_due_turn,
  input wire logic [mtpq_pkg::KEY_W-1:0] out_sequence,
  input wire logic [mtpq_pkg::OCC_W-1:0] out_occupancy
);
  import mtpq_pkg::*;

  // one operation in flight: an accepted beat closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an operation is in flight");

  // failed operations carry no entry
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY || out_status == ST_FULL)) |->
      (out_symbol == '0 && out_due_turn == '0 && out_sequence == '0))
    else $error("entry fields not zero on empty or full result");

  // empty report means nothing held
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_occupancy == '0))
    else $error("empty result with nonzero occupancy");

  // full report means the queue is at capacity
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_occupancy == OCC_W'(QUEUE_DEPTH)))
    else $error("full result with occupancy below capacity");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_symbol) &&
       $stable(out_due_turn) && $stable(out_sequence) && $stable(out_occupancy)))
    else $error("stalled result changed");

endmodule

bind min_turn_priority_queue mtpq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_mtpq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_symbol    (out_symbol),
  .out_due_turn  (out_due_turn),
  .out_sequence  (out_sequence),
  .out_occupancy (out_occupancy)
);

`default_nettype wire
